// File: src/pidc_pkg.sv
// shared constants, types and reset values of the multichannel pid controller
// no dependencies; every other file imports this package
package pidc_pkg;

   localparam int CHANNELS_DEFAULT = 16;

   // field widths
   localparam int CHAN_W    = 4;
   localparam int DATA_W    = 32;
   localparam int ELAPSED_W = 16;
   localparam int MASK_W    = 16;
   localparam int WINDOW_W  = 31;
   localparam int INT_W     = 48;
   localparam int DIFF_W    = DATA_W + 1;
   localparam int FRAC_W    = 16;

   // digit-serial multiply-accumulate
   localparam int SUM_W   = 84;
   localparam int DIGIT_W = 4;
   localparam int DIGITS  = SUM_W / DIGIT_W;
   localparam int CNT_W   = $clog2(DIGITS);
   localparam int PROD_W  = DATA_W + DIGIT_W + 1;
   localparam int STEP_W  = PROD_W + 1;
   localparam int CARRY_W = STEP_W - DIGIT_W;

   // register file
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_MASK     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P          = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I          = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D          = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEGRAL_WINDOW = 3'd4;

   localparam logic [MASK_W-1:0]          ENABLE_MASK_RESET = '0;
   localparam logic signed [DATA_W-1:0]   GAIN_P_RESET      = 32'sd124518;
   localparam logic signed [DATA_W-1:0]   GAIN_I_RESET      = 32'sd131;
   localparam logic signed [DATA_W-1:0]   GAIN_D_RESET      = 32'sd3277;
   localparam logic [WINDOW_W-1:0]        WINDOW_RESET      = 31'd50;

   // saturation limits
   localparam logic [DATA_W-1:0] S32_MAX = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0] S32_MIN = 32'h8000_0000;
   localparam logic [INT_W-1:0]  S48_MAX = 48'h7fff_ffff_ffff;
   localparam logic [INT_W-1:0]  S48_MIN = 48'h8000_0000_0000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_RUN,
      ST_SETUP,
      ST_FINISH
   } state_type;

   // which product the serial unit is working on
   typedef enum logic [1:0] {
      PASS_ACCUM,
      PASS_PROP,
      PASS_INTEG,
      PASS_DERIV
   } pass_type;

   typedef struct packed {
      logic step;
      logic load_sum;
      logic load_mplier;
   } mac_ctrl_type;

endpackage

// File: src/pidc_req_if.sv
// request channel of the pid controller: valid/ready with one control sample
// depends on pidc_pkg
interface pidc_req_if;
   import pidc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CHAN_W-1:0]         channel;
   logic signed [DATA_W-1:0]  target;
   logic signed [DATA_W-1:0]  measured;
   logic [ELAPSED_W-1:0]      elapsed_ms;

   modport source (output valid, output channel, output target, output measured,
                   output elapsed_ms, input ready);
   modport sink   (input valid, input channel, input target, input measured,
                   input elapsed_ms, output ready);
endinterface

// File: src/pidc_rsp_if.sv
// response channel of the pid controller: valid/ready with one drive value
// depends on pidc_pkg
interface pidc_rsp_if;
   import pidc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CHAN_W-1:0]         out_channel;
   logic signed [DATA_W-1:0]  drive;

   modport source (output valid, output out_channel, output drive, input ready);
   modport sink   (input valid, input out_channel, input drive, output ready);
endinterface

// File: src/pidc_serial_mac.sv
// digit-serial multiply-accumulate: sum += mcand * mplier, one digit per step
// depends on pidc_pkg
module pidc_serial_mac (
   input  logic                              clock,
   input  pidc_pkg::mac_ctrl_type            ctrl,
   input  logic signed [pidc_pkg::DATA_W-1:0] mcand,
   input  logic [pidc_pkg::SUM_W-1:0]        load_sum,
   input  logic [pidc_pkg::SUM_W-1:0]        load_mplier,
   output logic [pidc_pkg::SUM_W-1:0]        sum
);
   import pidc_pkg::*;

   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [SUM_W-1:0]          mplier_ff, mplier_in;
   logic signed [CARRY_W-1:0] carry_ff, carry_in;

   logic [DIGIT_W-1:0]        digit;
   logic signed [PROD_W-1:0]  mcand_x, digit_x, product;
   logic signed [STEP_W-1:0]  step_val;

   always_comb begin
      digit    = mplier_ff[DIGIT_W-1:0];
      mcand_x  = PROD_W'(mcand);
      digit_x  = PROD_W'(digit);
      product  = mcand_x * digit_x;
      // carry, partial product and the stored digit of the running sum
      step_val = STEP_W'(carry_ff) + STEP_W'(product) + STEP_W'(sum_ff[DIGIT_W-1:0]);

      sum_in    = sum_ff;
      mplier_in = mplier_ff;
      carry_in  = carry_ff;
      if (ctrl.load_sum) begin
         sum_in = load_sum;
      end
      if (ctrl.load_mplier) begin
         mplier_in = load_mplier;
         carry_in  = '0;
      end else if (ctrl.step) begin
         sum_in    = {step_val[DIGIT_W-1:0], sum_ff[SUM_W-1:DIGIT_W]};
         mplier_in = {{DIGIT_W{mplier_ff[SUM_W-1]}}, mplier_ff[SUM_W-1:DIGIT_W]};
         carry_in  = step_val[STEP_W-1:DIGIT_W];
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      mplier_ff <= mplier_in;
      carry_ff  <= carry_in;
   end

   assign sum = sum_ff;

endmodule

// File: src/multichannel_pid_controller_top.sv
// top level of the multichannel pid controller: registers, channel state, control
// depends on pidc_pkg, pidc_req_if, pidc_rsp_if and pidc_serial_mac
//
// usage
//   req_bus carries one control sample (channel, target, measured, elapsed_ms);
//   it is taken at a clock edge with valid and ready high. rsp_bus returns one
//   drive value for each request of an enabled channel; requests of disabled or
//   absent channels are dropped and leave no trace.
//   csr_we/csr_index/csr_wdata write the mask, the three gains and the window;
//   write only while no request is in flight.
// sequencing
//   one request at a time. an accepted request of an enabled channel shows its
//   response valid at the same edge where ready returns, so the next request
//   can follow only then. the work runs on the shared 32x4 digit-serial
//   multiplier: four passes of 21 digits (integral update, then the p, i and d
//   products into an 84-bit running sum), after a fetch state, with a setup
//   state between passes and a finish state that loads the output register.
// reset and stall
//   reset restores the register defaults and marks all channel state as zero
//   at once; no clearing pass. a response waiting in the output register does
//   not stop a new request from being taken; only the finish of that request
//   waits until the output register is free.
module multichannel_pid_controller_top #(
   parameter int CHANNELS = pidc_pkg::CHANNELS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   pidc_req_if.sink                            req_bus,
   pidc_rsp_if.source                          rsp_bus,
   input  logic                                csr_we,
   input  logic [pidc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pidc_pkg::DATA_W-1:0]         csr_wdata
);
   import pidc_pkg::*;

   localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ENTRY_W = INT_W + DATA_W;

   // configuration registers
   logic [MASK_W-1:0]         enable_mask_ff;
   logic signed [DATA_W-1:0]  gain_p_ff, gain_i_ff, gain_d_ff;
   logic [WINDOW_W-1:0]       window_ff;

   // control
   state_type                 state_ff, state_in;
   pass_type                  pass_ff, pass_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;

   // request payload and working values
   logic [CHAN_W-1:0]         channel_ff, channel_in;
   logic [ELAPSED_W-1:0]      elapsed_ff, elapsed_in;
   logic signed [DATA_W-1:0]  err_ff, err_in;
   logic signed [DIFF_W-1:0]  d_ff, d_in;
   logic [INT_W-1:0]          int_ff, int_in;
   logic                      integ_ff, integ_in;

   // per-channel state memory: {integral, previous error}
   logic [ENTRY_W-1:0]        state_mem [CHANNELS];
   logic [ENTRY_W-1:0]        rd_ff;
   logic                      rdv_ff;
   logic [CHANNELS-1:0]       valid_ff;
   logic [IDX_W-1:0]          rd_idx, wr_idx;
   logic                      mem_we;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]         rsp_channel_ff;
   logic [DATA_W-1:0]         rsp_drive_ff;
   logic [DATA_W-1:0]         drive_val;
   logic                      out_free, out_load;

   // serial unit
   mac_ctrl_type              mac_ctrl;
   logic signed [DATA_W-1:0]  mac_mcand;
   logic [SUM_W-1:0]          mac_load_sum, mac_load_mplier, mac_sum;

   // combinational helpers
   logic                      req_accept, item_live;
   logic signed [DIFF_W-1:0]  diff;
   logic [INT_W-1:0]          old_int, int_new, int_sat;
   logic [DATA_W-1:0]         old_prev, mag;
   logic [SUM_W-INT_W:0]      int_hi;
   logic [SUM_W-FRAC_W-DIFF_W:0] q_hi;
   logic                      sum_neg, round_up;
   logic [DIFF_W:0]           rounded;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign item_live     = (32'(req_bus.channel) < CHANNELS) &&
                          enable_mask_ff[req_bus.channel];
   assign rd_idx        = IDX_W'(req_bus.channel);
   assign wr_idx        = IDX_W'(channel_ff);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_mask_ff <= ENABLE_MASK_RESET;
         gain_p_ff      <= GAIN_P_RESET;
         gain_i_ff      <= GAIN_I_RESET;
         gain_d_ff      <= GAIN_D_RESET;
         window_ff      <= WINDOW_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE_MASK:     enable_mask_ff <= csr_wdata[MASK_W-1:0];
            CSR_GAIN_P:          gain_p_ff      <= csr_wdata;
            CSR_GAIN_I:          gain_i_ff      <= csr_wdata;
            CSR_GAIN_D:          gain_d_ff      <= csr_wdata;
            CSR_INTEGRAL_WINDOW: window_ff      <= csr_wdata[WINDOW_W-1:0];
            default: begin
               // unknown index: ignored
            end
         endcase
      end
   end

   // sequencer: fetch, four serial passes with a setup between, finish
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cnt_in   = cnt_ff;
      mac_ctrl = '0;
      mem_we   = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && item_live) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            mac_ctrl.load_sum    = 1'b1;
            mac_ctrl.load_mplier = 1'b1;
            pass_in              = PASS_ACCUM;
            cnt_in               = '0;
            state_in             = ST_RUN;
         end
         ST_RUN: begin
            mac_ctrl.step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIGITS - 1)) begin
               cnt_in   = '0;
               state_in = (pass_ff == PASS_DERIV) ? ST_FINISH : ST_SETUP;
            end
         end
         ST_SETUP: begin
            // after the integral pass the sum restarts from zero
            mac_ctrl.load_mplier = 1'b1;
            mac_ctrl.load_sum    = (pass_ff == PASS_ACCUM);
            mem_we               = (pass_ff == PASS_ACCUM);
            pass_in              = pass_type'(pass_ff + 2'd1);
            state_in             = ST_RUN;
         end
         ST_FINISH: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= PASS_ACCUM;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         cnt_ff   <= cnt_in;
      end
   end

   // datapath next values
   always_comb begin
      // saturated position error
      diff = {req_bus.target[DATA_W-1], req_bus.target} -
             {req_bus.measured[DATA_W-1], req_bus.measured};

      // stored state of a channel never written reads as zero
      old_int  = rdv_ff ? rd_ff[ENTRY_W-1:DATA_W] : '0;
      old_prev = rdv_ff ? rd_ff[DATA_W-1:0] : '0;
      mag      = err_ff[DATA_W-1] ? (DATA_W'(0) - err_ff) : err_ff;

      // integral after the first pass, clamped to 48 bits; zero while integration is off
      int_hi  = mac_sum[SUM_W-1:INT_W-1];
      int_sat = ((&int_hi) || !(|int_hi)) ? mac_sum[INT_W-1:0] :
                (mac_sum[SUM_W-1] ? S48_MIN : S48_MAX);
      int_new = integ_ff ? int_sat : '0;

      channel_in = channel_ff;
      elapsed_in = elapsed_ff;
      err_in     = err_ff;
      d_in       = d_ff;
      integ_in   = integ_ff;
      int_in     = int_ff;
      if (req_accept) begin
         channel_in = req_bus.channel;
         elapsed_in = req_bus.elapsed_ms;
         if (diff[DIFF_W-1] != diff[DIFF_W-2]) begin
            err_in = diff[DIFF_W-1] ? S32_MIN : S32_MAX;
         end else begin
            err_in = diff[DATA_W-1:0];
         end
      end
      if (state_ff == ST_FETCH) begin
         d_in     = {err_ff[DATA_W-1], err_ff} - {old_prev[DATA_W-1], old_prev};
         integ_in = (gain_i_ff != '0) && (mag < {1'b0, window_ff});
      end
      if (state_ff == ST_SETUP && pass_ff == PASS_ACCUM) begin
         int_in = int_new;
      end
   end

   always_ff @(posedge clock) begin
      channel_ff <= channel_in;
      elapsed_ff <= elapsed_in;
      err_ff     <= err_in;
      d_ff       <= d_in;
      integ_ff   <= integ_in;
      int_ff     <= int_in;
   end

   // channel state memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         state_mem[wr_idx] <= {int_new, err_ff};
      end
      if (req_accept) begin
         rd_ff  <= state_mem[rd_idx];
         rdv_ff <= valid_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_we) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   // operands of the serial unit for each pass
   always_comb begin
      mac_load_sum    = '0;
      mac_load_mplier = '0;
      if (state_ff == ST_FETCH) begin
         mac_load_sum    = {{(SUM_W-INT_W){old_int[INT_W-1]}}, old_int};
         mac_load_mplier = SUM_W'(elapsed_ff);
      end else begin
         case (pass_ff)
            PASS_ACCUM: mac_load_mplier = {{(SUM_W-DATA_W){err_ff[DATA_W-1]}}, err_ff};
            PASS_PROP:  mac_load_mplier = {{(SUM_W-INT_W){int_ff[INT_W-1]}}, int_ff};
            PASS_INTEG: mac_load_mplier = {{(SUM_W-DIFF_W){d_ff[DIFF_W-1]}}, d_ff};
            default:    mac_load_mplier = '0;
         endcase
      end
      case (pass_ff)
         PASS_ACCUM: mac_mcand = err_ff;
         PASS_PROP:  mac_mcand = gain_p_ff;
         PASS_INTEG: mac_mcand = gain_i_ff;
         default:    mac_mcand = gain_d_ff;
      endcase
   end

   pidc_serial_mac u_mac (
      .clock       (clock),
      .ctrl        (mac_ctrl),
      .mcand       (mac_mcand),
      .load_sum    (mac_load_sum),
      .load_mplier (mac_load_mplier),
      .sum         (mac_sum)
   );

   // integer part of the q68.16 sum, toward zero, clamped to 32 bits
   always_comb begin
      sum_neg  = mac_sum[SUM_W-1];
      q_hi     = mac_sum[SUM_W-1:FRAC_W+DIFF_W-1];
      round_up = sum_neg && (|mac_sum[FRAC_W-1:0]);
      rounded  = {mac_sum[FRAC_W+DIFF_W-1], mac_sum[FRAC_W+DIFF_W-1:FRAC_W]} +
                 (DIFF_W+1)'(round_up);
      if (!((&q_hi) || !(|q_hi))) begin
         drive_val = sum_neg ? S32_MIN : S32_MAX;
      end else if ((&rounded[DIFF_W:DATA_W-1]) || !(|rounded[DIFF_W:DATA_W-1])) begin
         drive_val = rounded[DATA_W-1:0];
      end else begin
         drive_val = rounded[DIFF_W] ? S32_MIN : S32_MAX;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_channel_ff <= channel_ff;
         rsp_drive_ff   <= drive_val;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.out_channel = rsp_channel_ff;
   assign rsp_bus.drive       = rsp_drive_ff;

endmodule

// File: src/pidc_checker.sv
// port-level checks of the pid controller, bound to the top level
// depends on pidc_pkg and multichannel_pid_controller_top
module pidc_checker #(
   parameter int CHANNELS = pidc_pkg::CHANNELS_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [pidc_pkg::CHAN_W-1:0]   rsp_out_channel,
   input logic [pidc_pkg::DATA_W-1:0]   rsp_drive
);
   import pidc_pkg::*;

   // no response survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_drive) &&
                                  $stable(rsp_out_channel))
      else $error("stalled response changed");

   // a response is only loaded while no request can be taken
   a_busy_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared while request port was open");

   // responses only name channels that exist
   a_channel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_out_channel) < CHANNELS))
      else $error("response for a channel beyond the configured count");

endmodule

bind multichannel_pid_controller_top pidc_checker #(.CHANNELS(CHANNELS)) u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_out_channel (rsp_bus.out_channel),
   .rsp_drive       (rsp_bus.drive)
);
